/* rtl/core/array_table_search_remove_sort_core_defines.svh */
// assertion macros used by the checker file
`ifndef ARRAY_TABLE_SEARCH_REMOVE_SORT_CORE_DEFINES_SVH
`define ARRAY_TABLE_SEARCH_REMOVE_SORT_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define ATS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m: label");
// next-cycle implication checked outside reset
`define ATS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m: label");
`endif

/* rtl/core/ats_pkg.sv */
// ---------------------------------------------------------------------------
// ats_pkg
// Shared types and codes of the table search, remove and sort core.
// ---------------------------------------------------------------------------
`default_nettype none
package ats_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW = 6;
  localparam int unsigned CntW = 7;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0, KIND_SEARCH = 3'd1, KIND_REM_FIRST = 3'd2,
    KIND_REM_ALL = 3'd3, KIND_SORT_UP = 3'd4, KIND_SORT_DOWN = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic signed [DataW-1:0] value;
    logic                  start_new;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IdxW-1:0]       index;
    logic signed [DataW-1:0] element;
    logic [CntW-1:0]       fill_count;
    logic [CntW-1:0]       removed_count;
    logic                  last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_APPEND, S_WALK_RD, S_WALK_CMP, S_SHIFT_RD,
    S_SHIFT_WR, S_FINISH, S_SORT_I, S_SORT_LDA, S_SORT_RD, S_SORT_CMP,
    S_EMIT_RD, S_EMIT_OUT
  } state_t;

  // which result the output register forms
  typedef enum logic [2:0] {
    RES_PLAIN  = 3'd0, // status only
    RES_HIT    = 3'd1, // ok with the held hit position and the item value
    RES_APPEND = 3'd2,
    RES_REMALL = 3'd3,
    RES_ELEM   = 3'd4  // ok with i and the read data
  } res_t;

  // controller commands to the datapath
  typedef struct packed {
    logic ld_item;      // capture the input item
    logic clr_fill;     // empty the table
    logic clr_op;       // clear k, removed count and hit flag
    logic set_i;        // i <= 0
    logic inc_i;
    logic set_j;        // j <= i + 1
    logic inc_j;
    logic set_k_i;      // k <= i
    logic inc_k;
    logic inc_rem;
    logic set_found;    // note a hit
    logic set_hit;      // hold i as the hit position
    logic cap_a;        // capture read data as a
    logic wr_append;    // write value at fill, bump fill
    logic wr_k;         // write read data at k
    logic wr_j_a;       // write a at j
    logic wr_i_a;       // write a at i
    logic rd_j;         // read address j
    logic rd_k1;        // read address k + 1
    logic dec_fill;
    logic set_fill_k;
    res_t res_sel;
    logic res_last;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       start_new;
    logic       fill_zero;
    logic       fill_full;
    logic       i_end;      // i + 1 >= fill
    logic       i_at_fill;  // i >= fill
    logic       j_at_fill;  // j >= fill
    logic       k_end;      // k + 1 >= fill
    logic       rd_match;   // read data equals the item value
    logic       swap;       // a and read data out of order
    logic       found;
    logic       out_busy;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/core/array_table_search_remove_sort_core.sv */
// ---------------------------------------------------------------------------
// array_table_search_remove_sort_core
// Table of signed 32-bit values with search, remove and exchange sort.
// ---------------------------------------------------------------------------
// One item at a time: in_stall stays high until the block is idle again.
// The single RAM port with its registered read splits each step in two: a
// state that sets the read address, then a state that uses the read data.
// A held output (out_stall) holds the sequencer where it has a result to load.
`default_nettype none
module array_table_search_remove_sort_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ats_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ats_pkg::out_item_t      out_item
);
  ats_pkg::cmd_t cmd;
  ats_pkg::sts_t sts;

  ats_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  ats_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .cmd(cmd), .sts(sts),
    .out_item(out_item), .out_valid(out_valid), .out_stall(out_stall)
  );
endmodule
`default_nettype wire

/* rtl/core/ats_ram.sv */
// ---------------------------------------------------------------------------
// ats_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module ats_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, with a registered read of the old contents at the same address
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/core/ats_datapath.sv */
// ---------------------------------------------------------------------------
// ats_datapath
// Table memory, pointers, counters and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module ats_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ats_pkg::in_item_t in_item,
  input  wire ats_pkg::cmd_t     cmd,
  output ats_pkg::sts_t          sts,
  output ats_pkg::out_item_t     out_item,
  output logic                   out_valid,
  input  wire logic              out_stall
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [6:0] DepthC = 7'(DEPTH);

  ats_pkg::in_item_t item;
  ats_pkg::out_item_t out_item_next;
  logic [6:0]  fill, i, j, k, k_inc, rem, hit;
  logic [31:0] a, rdata, wdata;
  logic        found, we;
  logic [AW-1:0] addr;

  assign k_inc = k + 7'd1;

  // single port: pick address and data from the command
  always_comb begin
    we = 1'b0;
    wdata = a;
    addr = i[AW-1:0];
    if (cmd.wr_append) begin
      we = 1'b1; wdata = item.value; addr = fill[AW-1:0];
    end else if (cmd.wr_k) begin
      we = 1'b1; wdata = rdata; addr = k[AW-1:0];
    end else if (cmd.wr_j_a) begin
      we = 1'b1; addr = j[AW-1:0];
    end else if (cmd.wr_i_a) begin
      we = 1'b1; addr = i[AW-1:0];
    end else if (cmd.rd_j) begin
      addr = j[AW-1:0];
    end else if (cmd.rd_k1) begin
      addr = k_inc[AW-1:0];
    end
  end

  ats_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // item, operand and pointer registers
  always_ff @(posedge clk) begin
    if (cmd.ld_item) item <= in_item;
    if (cmd.cap_a) a <= rdata;
    if (cmd.set_i) i <= '0;
    else if (cmd.inc_i) i <= i + 7'd1;
    if (cmd.set_j) j <= i + 7'd1;
    else if (cmd.inc_j) j <= j + 7'd1;
    if (cmd.clr_op) k <= '0;
    else if (cmd.set_k_i) k <= i;
    else if (cmd.inc_k) k <= k_inc;
    if (cmd.clr_op) rem <= '0;
    else if (cmd.inc_rem) rem <= rem + 7'd1;
    if (cmd.clr_op) found <= 1'b0;
    else if (cmd.set_found) found <= 1'b1;
    if (cmd.set_hit) hit <= i;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.clr_fill) begin
      fill <= '0;
    end else if (cmd.wr_append) begin
      fill <= fill + 7'd1;
    end else if (cmd.dec_fill) begin
      fill <= fill - 7'd1;
    end else if (cmd.set_fill_k) begin
      fill <= k;
    end
  end

  // status back to the controller
  always_comb begin
    sts.kind      = item.kind;
    sts.start_new = item.start_new;
    sts.fill_zero = (fill == '0);
    sts.fill_full = (fill >= DepthC);
    sts.i_end     = (i + 7'd1 >= fill);
    sts.i_at_fill = (i >= fill);
    sts.j_at_fill = (j >= fill);
    sts.k_end     = (k_inc >= fill);
    sts.rd_match  = ($signed(rdata) == item.value);
    sts.swap      = (item.kind == ats_pkg::KIND_SORT_UP) ? ($signed(a) > $signed(rdata))
                                                         : ($signed(rdata) > $signed(a));
    sts.found     = found;
    sts.out_busy  = out_valid && out_stall;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // form the result
  always_comb begin
    out_item_next.fill_count    = fill;
    out_item_next.last          = cmd.res_last;
    out_item_next.removed_count = '0;
    out_item_next.index         = '0;
    out_item_next.element       = '0;
    out_item_next.status        = ats_pkg::ST_OK;
    case (cmd.res_sel)
      ats_pkg::RES_PLAIN: begin
        if (item.kind == ats_pkg::KIND_APPEND) out_item_next.status = ats_pkg::ST_FULL;
        else if (fill == '0) out_item_next.status = ats_pkg::ST_EMPTY;
        else out_item_next.status = ats_pkg::ST_NOT_FOUND;
      end
      ats_pkg::RES_HIT: begin
        out_item_next.index   = hit[5:0];
        out_item_next.element = item.value;
        out_item_next.removed_count =
          (item.kind == ats_pkg::KIND_REM_FIRST) ? 7'd1 : 7'd0;
      end
      ats_pkg::RES_APPEND: begin
        out_item_next.index      = fill[5:0];
        out_item_next.element    = item.value;
        out_item_next.fill_count = fill + 7'd1;
      end
      ats_pkg::RES_REMALL: begin
        out_item_next.element       = item.value;
        out_item_next.removed_count = rem;
      end
      ats_pkg::RES_ELEM: begin
        out_item_next.index   = i[5:0];
        out_item_next.element = rdata;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) out_item <= out_item_next;
  end
endmodule
`default_nettype wire

/* rtl/core/ats_ctrl.sv */
// ---------------------------------------------------------------------------
// ats_ctrl
// Sequencer for append, search, remove and exchange sort.
// ---------------------------------------------------------------------------
`default_nettype none
module ats_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ats_pkg::sts_t sts,
  output ats_pkg::cmd_t      cmd
);
  ats_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ats_pkg::S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ats_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_next = ats_pkg::S_DISPATCH;
        end
      end
      // dispatch the captured item
      ats_pkg::S_DISPATCH: begin
        cmd.set_i = 1'b1;
        cmd.clr_op = 1'b1;
        if (sts.kind == ats_pkg::KIND_APPEND) begin
          cmd.clr_fill = sts.start_new;
          state_next = ats_pkg::S_APPEND;
        end else if (!(sts.kind inside {[ats_pkg::KIND_SEARCH:ats_pkg::KIND_SORT_DOWN]}))
        begin
          state_next = ats_pkg::S_IDLE;
        end else if (sts.fill_zero) begin
          if (!sts.out_busy) begin
            cmd.res_load = 1'b1; cmd.res_sel = ats_pkg::RES_PLAIN; cmd.res_last = 1'b1;
            state_next = ats_pkg::S_IDLE;
          end
        end else if (sts.kind inside {ats_pkg::KIND_SORT_UP, ats_pkg::KIND_SORT_DOWN}) begin
          state_next = ats_pkg::S_SORT_I;
        end else begin
          state_next = ats_pkg::S_WALK_RD;
        end
      end
      // append or report a full table
      ats_pkg::S_APPEND: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1; cmd.res_last = 1'b1;
          if (sts.fill_full) begin
            cmd.res_sel = ats_pkg::RES_PLAIN;
          end else begin
            cmd.res_sel = ats_pkg::RES_APPEND; cmd.wr_append = 1'b1;
          end
          state_next = ats_pkg::S_IDLE;
        end
      end
      // walk i over the table, reading at i
      ats_pkg::S_WALK_RD: begin
        if (sts.i_at_fill) begin
          cmd.set_fill_k = (sts.kind == ats_pkg::KIND_REM_ALL);
          state_next = ats_pkg::S_FINISH;
        end else begin
          state_next = ats_pkg::S_WALK_CMP;
        end
      end
      ats_pkg::S_WALK_CMP: begin
        if (sts.kind == ats_pkg::KIND_SEARCH) begin
          // a hit is held back until the next one shows it is not the last
          if (!(sts.rd_match && sts.found && sts.out_busy)) begin
            if (sts.rd_match) begin
              cmd.set_hit = 1'b1; cmd.set_found = 1'b1;
              if (sts.found) begin
                cmd.res_load = 1'b1; cmd.res_sel = ats_pkg::RES_HIT;
              end
            end
            cmd.inc_i = 1'b1;
            state_next = ats_pkg::S_WALK_RD;
          end
        end else if (sts.kind == ats_pkg::KIND_REM_FIRST) begin
          if (sts.rd_match) begin
            cmd.set_hit = 1'b1; cmd.set_found = 1'b1; cmd.set_k_i = 1'b1;
            state_next = ats_pkg::S_SHIFT_RD;
          end else begin
            cmd.inc_i = 1'b1;
            state_next = ats_pkg::S_WALK_RD;
          end
        end else begin
          // remove all: compact kept entries down to k
          if (sts.rd_match) begin
            cmd.inc_rem = 1'b1; cmd.set_found = 1'b1;
          end else begin
            cmd.wr_k = 1'b1; cmd.inc_k = 1'b1;
          end
          cmd.inc_i = 1'b1;
          state_next = ats_pkg::S_WALK_RD;
        end
      end
      // close the gap one entry at a time
      ats_pkg::S_SHIFT_RD: begin
        if (sts.k_end) begin
          cmd.dec_fill = 1'b1;
          state_next = ats_pkg::S_FINISH;
        end else begin
          cmd.rd_k1 = 1'b1;
          state_next = ats_pkg::S_SHIFT_WR;
        end
      end
      ats_pkg::S_SHIFT_WR: begin
        cmd.wr_k = 1'b1;
        cmd.inc_k = 1'b1;
        state_next = ats_pkg::S_SHIFT_RD;
      end
      // final result of search and remove
      ats_pkg::S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1; cmd.res_last = 1'b1;
          if (!sts.found) cmd.res_sel = ats_pkg::RES_PLAIN;
          else if (sts.kind == ats_pkg::KIND_REM_ALL) cmd.res_sel = ats_pkg::RES_REMALL;
          else cmd.res_sel = ats_pkg::RES_HIT;
          state_next = ats_pkg::S_IDLE;
        end
      end
      // sort: a holds the entry at i while j runs over the rest
      ats_pkg::S_SORT_I: begin
        if (sts.i_end) begin
          cmd.set_i = 1'b1;
          state_next = ats_pkg::S_EMIT_RD;
        end else begin
          state_next = ats_pkg::S_SORT_LDA;
        end
      end
      ats_pkg::S_SORT_LDA: begin
        cmd.cap_a = 1'b1;
        cmd.set_j = 1'b1;
        state_next = ats_pkg::S_SORT_RD;
      end
      ats_pkg::S_SORT_RD: begin
        if (sts.j_at_fill) begin
          cmd.wr_i_a = 1'b1;
          cmd.inc_i = 1'b1;
          state_next = ats_pkg::S_SORT_I;
        end else begin
          cmd.rd_j = 1'b1;
          state_next = ats_pkg::S_SORT_CMP;
        end
      end
      ats_pkg::S_SORT_CMP: begin
        if (sts.swap) begin
          cmd.wr_j_a = 1'b1;
          cmd.cap_a = 1'b1;
        end
        cmd.inc_j = 1'b1;
        state_next = ats_pkg::S_SORT_RD;
      end
      // emit every element in order
      ats_pkg::S_EMIT_RD: begin
        if (sts.i_at_fill) state_next = ats_pkg::S_IDLE;
        else state_next = ats_pkg::S_EMIT_OUT;
      end
      ats_pkg::S_EMIT_OUT: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1; cmd.res_sel = ats_pkg::RES_ELEM; cmd.res_last = sts.i_end;
          cmd.inc_i = 1'b1;
          state_next = ats_pkg::S_EMIT_RD;
        end
      end
      default: state_next = ats_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/core/ats_checker.sv */
// ---------------------------------------------------------------------------
// ats_checker
// Port-level checks of the table core.
// ---------------------------------------------------------------------------
`default_nettype none
`include "array_table_search_remove_sort_core_defines.svh"
module ats_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ats_pkg::out_item_t out_item
);
  // a waiting result holds
  `ATS_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, $stable(out_item))
  // fill never passes the table size
  `ATS_ASSERT_IMP(a_fill, clk, rst, out_valid, out_item.fill_count <= 7'd64)
  // not-found and empty results carry no element
  `ATS_ASSERT_IMP(a_zero, clk, rst,
    out_valid && (out_item.status == ats_pkg::ST_NOT_FOUND ||
    out_item.status == ats_pkg::ST_EMPTY), out_item.element == '0)
  // failing results are always single and last
  `ATS_ASSERT_IMP(a_last, clk, rst, out_valid && out_item.status != ats_pkg::ST_OK,
    out_item.last)
  // one item at a time: busy right after an accepted item
  `ATS_ASSERT_NEXT(a_busy, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind array_table_search_remove_sort_core ats_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Checks the table core against a behavioural table model: directed items
// for the corner cases, then random sequences of appends, searches, removes
// and sorts, with random gaps on the input and random stalls on the output.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ats_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ats_pkg::out_item_t out_item;

  ats_pkg::in_item_t pending_items[$];
  ats_pkg::out_item_t expected_results[$];
  logic signed [31:0] tbl[TableDepth];
  int unsigned fill_level = 0;
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  array_table_search_remove_sort_core #(.DEPTH(TableDepth)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // queue one result of the table model
  function automatic void push_result(logic [1:0] st, int unsigned idx,
                                      logic signed [31:0] el, int unsigned rem, bit lst);
    ats_pkg::out_item_t r;
    r.status = st;
    r.index = idx[5:0];
    r.element = el;
    r.fill_count = fill_level[6:0];
    r.removed_count = rem[6:0];
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  // apply one item to the table model and queue what it produces
  function automatic void table_apply(ats_pkg::in_item_t it);
    int unsigned hits;
    int unsigned kept;
    logic signed [31:0] t;
    bit sw;
    hits = 0;
    if (it.kind == ats_pkg::KIND_APPEND) begin
      if (it.start_new) fill_level = 0;
      if (fill_level >= TableDepth) begin
        push_result(ats_pkg::ST_FULL, 0, 0, 0, 1'b1);
      end else begin
        tbl[fill_level] = it.value;
        fill_level++;
        push_result(ats_pkg::ST_OK, fill_level - 1, it.value, 0, 1'b1);
      end
      return;
    end
    if (it.kind > ats_pkg::KIND_SORT_DOWN) return;
    if (fill_level == 0) begin
      push_result(ats_pkg::ST_EMPTY, 0, 0, 0, 1'b1);
      return;
    end
    case (it.kind)
      ats_pkg::KIND_SEARCH: begin
        for (int i = 0; i < fill_level; i++)
          if (tbl[i] == it.value) hits++;
        if (hits == 0) push_result(ats_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1);
        for (int i = 0; i < fill_level; i++)
          if (tbl[i] == it.value) begin
            hits--;
            push_result(ats_pkg::ST_OK, i, it.value, 0, hits == 0);
          end
      end
      ats_pkg::KIND_REM_FIRST: begin
        for (int i = 0; i < fill_level; i++)
          if (tbl[i] == it.value) begin
            for (int k = i; k + 1 < fill_level; k++) tbl[k] = tbl[k + 1];
            fill_level--;
            push_result(ats_pkg::ST_OK, i, it.value, 1, 1'b1);
            return;
          end
        push_result(ats_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1);
      end
      ats_pkg::KIND_REM_ALL: begin
        kept = 0;
        for (int i = 0; i < fill_level; i++)
          if (tbl[i] == it.value) hits++;
          else begin
            tbl[kept] = tbl[i];
            kept++;
          end
        fill_level = kept;
        if (hits == 0) push_result(ats_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1);
        else push_result(ats_pkg::ST_OK, 0, it.value, hits, 1'b1);
      end
      default: begin
        for (int i = 0; i + 1 < fill_level; i++)
          for (int j = i + 1; j < fill_level; j++) begin
            sw = (it.kind == ats_pkg::KIND_SORT_UP) ? (tbl[i] > tbl[j]) : (tbl[j] > tbl[i]);
            if (sw) begin
              t = tbl[i];
              tbl[i] = tbl[j];
              tbl[j] = t;
            end
          end
        for (int i = 0; i < fill_level; i++)
          push_result(ats_pkg::ST_OK, i, tbl[i], 0, i + 1 == fill_level);
      end
    endcase
  endfunction

  function automatic ats_pkg::in_item_t make_item(logic [2:0] k, logic signed [31:0] v,
                                                  bit sn);
    ats_pkg::in_item_t it;
    it.kind = k;
    it.value = v;
    it.start_new = sn;
    return it;
  endfunction

  // values drawn from a small pool so that matches are common
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned n;
    logic [2:0] k;
    // empty table, then extremes, duplicates and every operation
    pending_items.push_back(make_item(ats_pkg::KIND_SEARCH, 5, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_SORT_UP, 0, 1'b1));
    pending_items.push_back(make_item(ats_pkg::KIND_REM_FIRST, 1, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_REM_ALL, 1, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, 32'sh7fff_ffff, 1'b1));
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, 32'sh8000_0000, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, -1, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, 32'sh7fff_ffff, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, 0, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_SEARCH, 32'sh7fff_ffff, 1'b1));
    pending_items.push_back(make_item(ats_pkg::KIND_SEARCH, 42, 1'b0));
    pending_items.push_back(make_item(3'd6, 0, 1'b0));
    pending_items.push_back(make_item(3'd7, -1, 1'b1));
    pending_items.push_back(make_item(ats_pkg::KIND_SORT_UP, 0, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_SORT_DOWN, -1, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_REM_FIRST, 32'sh7fff_ffff, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_REM_FIRST, 42, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_REM_ALL, 9, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, -1, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_REM_ALL, -1, 1'b0));
    // fill to capacity, then overflow
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, 7, 1'b1));
    for (int i = 1; i < TableDepth; i++)
      pending_items.push_back(make_item(ats_pkg::KIND_APPEND,
                                        $signed($urandom_range(0, 3)), 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_APPEND, 1, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_SEARCH, 2, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_SORT_DOWN, 0, 1'b0));
    pending_items.push_back(make_item(ats_pkg::KIND_REM_ALL, 3, 1'b0));
    // random part: appends most often to keep the table small but busy
    for (int i = 0; i < 60; i++) begin
      n = $urandom_range(0, 99);
      if (n < 45) k = ats_pkg::KIND_APPEND;
      else if (n < 60) k = ats_pkg::KIND_SEARCH;
      else if (n < 72) k = ats_pkg::KIND_REM_FIRST;
      else if (n < 82) k = ats_pkg::KIND_REM_ALL;
      else if (n < 88) k = ats_pkg::KIND_SORT_UP;
      else if (n < 94) k = ats_pkg::KIND_SORT_DOWN;
      else k = 3'($urandom_range(6, 7));
      pending_items.push_back(make_item(k, pick_value(), $urandom_range(0, 24) == 0));
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      calm <= (items_sent >= 40 && items_sent < 80);
      if (in_valid && !in_stall) begin
        table_apply(in_item);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (pending_items.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ats_pkg::out_item_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_item);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item !== exp_r) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_item);
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 20);
    end
  end

  // end of run
  initial begin
    wait (stim_done && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("ran %0d items through the table, %0d results checked",
             items_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/ats_pkg.sv
rtl/core/ats_ram.sv
rtl/core/ats_datapath.sv
rtl/core/ats_ctrl.sv
rtl/core/array_table_search_remove_sort_core.sv
rtl/core/ats_checker.sv
test/tb.sv
